/* rtl/dnsenc_pkg.sv */
// Shared constants and types for the DNS name wire encoder.
// No dependencies; compiled first.
package dnsenc_pkg;

  localparam int MAX_LABEL = 63;                      // longest label kept
  localparam int CNT_W     = $clog2(MAX_LABEL + 1);   // label length width
  localparam logic [7:0] DOT_CHAR = 8'd46;            // label separator

  // Control from the sequencer to the label cell row.
  typedef struct packed {
    logic             append;   // write wr_byte into the cell at count
    logic             shift;    // every cell takes its upper neighbor's word, the top cell zero
    logic [CNT_W-1:0] count;    // characters held for the current label
    logic [7:0]       wr_byte;  // character to store
  } chain_ctl_t;

endpackage

/* rtl/dnsenc_ifs.sv */
// Valid/ready channel interfaces for the encoder's input and result words.
// No dependencies.
interface dnsenc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_byte;

  modport source (output valid, cmd, char_byte, input ready);
  modport sink   (input valid, cmd, char_byte, output ready);
endinterface

interface dnsenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       label_overflow;

  modport source (output valid, out_byte, last, label_overflow, input ready);
  modport sink   (input valid, out_byte, last, label_overflow, output ready);
endinterface

/* rtl/dnsenc_cell.sv */
// One byte cell of the label buffer row.
// No dependencies; uses nothing from dnsenc_pkg.
module dnsenc_cell (
  input  logic       clk,
  input  logic       wr_en,
  input  logic       shift_en,
  input  logic [7:0] wr_byte,
  input  logic [7:0] nbr_byte,
  output logic [7:0] cell_byte
);

  logic [7:0] byte_r;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= wr_byte;
    end else if (shift_en) begin
      byte_r <= nbr_byte;
    end
  end

  assign cell_byte = byte_r;

endmodule

/* rtl/dnsenc_chain.sv */
// Row of MAX_LABEL byte cells holding the current label, oldest at cell 0.
// Depends on dnsenc_pkg and dnsenc_cell.
module dnsenc_chain
  import dnsenc_pkg::*;
(
  input  logic       clk,
  input  chain_ctl_t ctl,
  output logic [7:0] head_byte
);

  logic [7:0] cell_q [MAX_LABEL];

  for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
    logic [7:0] nbr;
    logic       sel;

    // a cell loads when the append points at its slot
    assign sel = ctl.append && (ctl.count == CNT_W'(i));

    if (i == MAX_LABEL - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    dnsenc_cell u_cell (
      .clk       (clk),
      .wr_en     (sel),
      .shift_en  (ctl.shift),
      .wr_byte   (ctl.wr_byte),
      .nbr_byte  (nbr),
      .cell_byte (cell_q[i])
    );
  end

  assign head_byte = cell_q[0];

endmodule

/* rtl/dns_name_wire_encoder.sv */
// DNS name to wire form encoder: top level with sequencer and output register.
// Depends on dnsenc_pkg, dnsenc_ifs and dnsenc_chain.
//
// A dotted name enters one character word at a time (cmd = 0) and is closed by
// an end word (cmd = 1). Label characters go into a row of 63 byte cells and
// produce nothing; a dot or the end word sends the length byte and then the
// label bytes out, one result word per cycle while the sink is ready, the
// cell row shifting toward its head so each byte is replayed from cell 0. A
// character word leaves the input open unless a held-back root zero must go out
// first; a dot or end word closes the input until the bytes it sends, behind any
// held-back root zero, have all entered the single-byte output register. The
// final byte of a name carries last. A leading
// dot holds back a zero byte: the name "." gives a single zero with last, and
// an empty name gives one zero with last. A label longer than 63 characters
// keeps its first 63, reports 63 as its length and flags label_overflow on
// every byte of that label. The input is taken again while the final result
// word still waits in the output register. No start-up pass after reset.
module dns_name_wire_encoder
  import dnsenc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  dnsenc_in_if.sink          in_ch,
  dnsenc_out_if.source       out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;  // taking words
  localparam logic [1:0] ST_ROOTZ = 2'd1;  // send held-back root zero
  localparam logic [1:0] ST_LEN   = 2'd2;  // send length byte
  localparam logic [1:0] ST_DATA  = 2'd3;  // replay label bytes

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;    // label length, then bytes left
  logic             ovf_r, ovf_nxt;        // current label lost characters
  logic             chars_r, chars_nxt;    // something came in this name
  logic             root_r, root_nxt;      // leading dot zero held back
  logic             end_r, end_nxt;        // flush closes the name
  logic             flush_r, flush_nxt;    // root zero followed by a flush

  logic             ov_r, ov_nxt;          // output word valid
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic             oo_r, oo_nxt;

  chain_ctl_t       ctl;
  logic [7:0]       head_byte;
  logic             acc, is_dot, emit_go;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_dot      = (in_ch.char_byte == DOT_CHAR);
  assign emit_go     = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    chars_nxt   = chars_r;
    root_nxt    = root_r;
    end_nxt     = end_r;
    flush_nxt   = flush_r;
    ctl.append  = 1'b0;
    ctl.shift   = 1'b0;
    ctl.count   = count_r;
    ctl.wr_byte = in_ch.char_byte;
    ov_nxt      = ov_r && !out_ch.ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    oo_nxt      = oo_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.cmd) begin
            chars_nxt = 1'b0;
            root_nxt  = 1'b0;
            end_nxt   = 1'b1;
            flush_nxt = 1'b0;
            state_nxt = root_r ? ST_ROOTZ : ST_LEN;
          end else if (is_dot && !chars_r) begin
            // leading dot: zero byte waits to see what follows
            chars_nxt = 1'b1;
            root_nxt  = 1'b1;
          end else begin
            chars_nxt = 1'b1;
            root_nxt  = 1'b0;
            end_nxt   = 1'b0;
            flush_nxt = is_dot;
            if (root_r) begin
              state_nxt = ST_ROOTZ;
            end else if (is_dot) begin
              state_nxt = ST_LEN;
            end
            if (!is_dot) begin
              if (count_r < CNT_W'(MAX_LABEL)) begin
                ctl.append = 1'b1;
                count_nxt  = count_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_ROOTZ: begin
        if (emit_go) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '0;
          ol_nxt    = end_r;
          oo_nxt    = 1'b0;
          state_nxt = flush_r ? ST_LEN : ST_IDLE;
        end
      end
      ST_LEN: begin
        if (emit_go) begin
          ov_nxt = 1'b1;
          ob_nxt = 8'(count_r);
          ol_nxt = end_r && (count_r == '0);
          oo_nxt = ovf_r;
          if (count_r == '0) begin
            state_nxt = ST_IDLE;
            ovf_nxt   = 1'b0;
          end else begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (emit_go) begin
          ov_nxt    = 1'b1;
          ob_nxt    = head_byte;
          ol_nxt    = end_r && (count_r == CNT_W'(1));
          oo_nxt    = ovf_r;
          ctl.shift = 1'b1;
          count_nxt = count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      chars_r <= 1'b0;
      root_r  <= 1'b0;
      end_r   <= 1'b0;
      flush_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      chars_r <= chars_nxt;
      root_r  <= root_nxt;
      end_r   <= end_nxt;
      flush_r <= flush_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    oo_r <= oo_nxt;
  end

  dnsenc_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .head_byte (head_byte)
  );

  assign out_ch.valid          = ov_r;
  assign out_ch.out_byte       = ob_r;
  assign out_ch.last           = ol_r;
  assign out_ch.label_overflow = oo_r;

endmodule

/* rtl/dnsenc_checker.sv */
// Port-level checks for the DNS name wire encoder, bound to the top level.
// Depends on dnsenc_pkg and dns_name_wire_encoder.
module dnsenc_checker
  import dnsenc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result word changed while stalled");

  // an end word always emits, so the input closes for the next cycle
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("input taken right after end word");

  // nothing is offered straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind dns_name_wire_encoder dnsenc_checker u_dnsenc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);

/* tb/sv/dnsenc_wire_checker.sv */
// Scoreboard for the DNS name wire encoder: predicts wire bytes from input words
// and compares them with the result channel. Depends on dnsenc_pkg, dnsenc_ifs.
module dnsenc_wire_checker
  import dnsenc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  dnsenc_in_if   in_mon,
  dnsenc_out_if  out_mon,
  output int     fail_count,
  output int     due_count,
  output int     bytes_checked
);

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       ovf;
  } wire_byte_t;

  wire_byte_t wire_bytes_due[$];

  // predictor state
  logic [7:0]  label_buf [MAX_LABEL];
  int unsigned label_len;
  bit          label_lost;
  bit          name_open;
  bit          root_pending;
  logic        word_held;

  task automatic push_byte(input logic [7:0] v, input logic l, input logic o);
    wire_byte_t wb;
    wb.value = v;
    wb.last  = l;
    wb.ovf   = o;
    wire_bytes_due.push_back(wb);
  endtask

  task automatic flush_label(input bit is_end);
    push_byte(8'(label_len), is_end && label_len == 0, label_lost);
    for (int unsigned i = 0; i < label_len; i++)
      push_byte(label_buf[i], is_end && i + 1 == label_len, label_lost);
    label_len  = 0;
    label_lost = 0;
  endtask

  task automatic encode_word(input logic cmd, input logic [7:0] ch);
    if (cmd) begin
      if (root_pending) push_byte(8'd0, 1'b1, 1'b0);
      else flush_label(1'b1);
      label_len    = 0;
      label_lost   = 0;
      name_open    = 0;
      root_pending = 0;
    end else if (ch == DOT_CHAR && !name_open) begin
      name_open    = 1;
      root_pending = 1;
    end else begin
      name_open = 1;
      if (root_pending) begin
        push_byte(8'd0, 1'b0, 1'b0);
        root_pending = 0;
      end
      if (ch == DOT_CHAR) flush_label(1'b0);
      else if (label_len < MAX_LABEL) begin
        label_buf[label_len] = ch;
        label_len++;
      end else label_lost = 1;
    end
  endtask

  // A word may be held at the input while an earlier word's bytes still go out,
  // so each word is predicted the first cycle it is presented; the source
  // never withdraws a presented word.
  always @(posedge clk) begin
    wire_byte_t wb;
    if (!rst_n) begin
      wire_bytes_due.delete();
      label_len     = 0;
      label_lost    = 0;
      name_open     = 0;
      root_pending  = 0;
      word_held     <= 1'b0;
      fail_count    <= 0;
      bytes_checked <= 0;
      due_count     <= 0;
    end else begin
      if (in_mon.valid && !word_held) encode_word(in_mon.cmd, in_mon.char_byte);
      word_held <= in_mon.valid && !in_mon.ready;

      if (out_mon.valid && out_mon.ready) begin
        bytes_checked <= bytes_checked + 1;
        if (wire_bytes_due.size() == 0) begin
          $error("result word with nothing expected: out_byte %0d", out_mon.out_byte);
          fail_count <= fail_count + 1;
        end else begin
          wb = wire_bytes_due.pop_front();
          if (out_mon.out_byte !== wb.value || out_mon.last !== wb.last ||
              out_mon.label_overflow !== wb.ovf)
            fail_count <= fail_count + 1;
          if (out_mon.out_byte !== wb.value)
            $error("out_byte: expected %0d, got %0d", wb.value, out_mon.out_byte);
          if (out_mon.last !== wb.last)
            $error("last: expected %0d, got %0d", wb.last, out_mon.last);
          if (out_mon.label_overflow !== wb.ovf)
            $error("label_overflow: expected %0d, got %0d", wb.ovf, out_mon.label_overflow);
        end
      end
      due_count <= wire_bytes_due.size();
    end
  end

endmodule

/* tb/sv/tb_dns_name_wire_encoder.sv */
// Top-level bench for the DNS name wire encoder: clock, reset, name stimulus
// and verdict. Depends on dnsenc_pkg, dnsenc_ifs and dnsenc_wire_checker.
module tb_dns_name_wire_encoder;
  import dnsenc_pkg::*;

  localparam int RANDOM_WORDS = 30;

  logic clk;
  logic rst_n;

  dnsenc_in_if  in_ch();
  dnsenc_out_if out_ch();

  int fail_count;
  int due_count;
  int bytes_checked;

  // idling knobs, percent of cycles
  int idle_pct;
  int stall_pct;

  int words_sent;
  int names_sent;

  dns_name_wire_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dnsenc_wire_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .bytes_checked (bytes_checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // One word on the input channel. Runs from a falling edge to a falling edge;
  // valid stays high when the next word follows without a gap.
  task automatic send_word(input logic cmd, input logic [7:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.char_byte <= ch;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (cmd) names_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_word(1'b0, ch);
  endtask

  task automatic end_name();
    send_word(1'b1, 8'($urandom_range(255)));
  endtask

  // Hold the input idle until every predicted byte has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
  endtask

  // wide: any byte but the dot; otherwise hostname-like characters
  function automatic logic [7:0] pick_char(input bit wide);
    logic [7:0] b;
    if (wide) begin
      do b = 8'($urandom_range(255)); while (b == DOT_CHAR);
    end else begin
      case ($urandom_range(3))
        0:       b = 8'("0") + 8'($urandom_range(9));
        1:       b = 8'("-");
        default: b = 8'("a") + 8'($urandom_range(25));
      endcase
    end
    return b;
  endfunction

  task automatic send_label(input int len, input bit wide);
    for (int i = 0; i < len; i++) send_char(pick_char(wide));
  endtask

  // Mostly well-formed names with random content; now and then a stray word.
  task automatic send_random_name();
    int nlabels;
    int len;
    if ($urandom_range(9) == 0) begin
      send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(7) == 0) send_char(DOT_CHAR);
    nlabels = $urandom_range(4);
    for (int k = 0; k < nlabels; k++) begin
      // rare long label to push past the 63-byte limit
      len = ($urandom_range(29) == 0) ? $urandom_range(60, 66) : $urandom_range(9);
      send_label(len, $urandom_range(3) == 0);
      if (k < nlabels - 1 || $urandom_range(2) == 0) send_char(DOT_CHAR);
    end
    end_name();
  endtask

  initial begin
    int base;
    int phase;
    int last_phase;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = 1'b0;
    in_ch.char_byte = 8'd0;
    out_ch.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    words_sent      = 0;
    names_sent      = 0;
    rst_n           = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed names, no idling.
    end_name();                                   // empty name: lone zero
    send_char(DOT_CHAR); send_word(1'b1, DOT_CHAR); // root name
    send_char(DOT_CHAR); send_char("a"); end_name();     // held-back zero, then label
    send_char(DOT_CHAR); send_char(DOT_CHAR); end_name(); // leading dot, empty label
    send_char(8'h00); send_char(8'hFF); send_char(DOT_CHAR); send_word(1'b1, 8'hFF);
    send_char("x"); end_name();                   // single-character name
    send_char("a"); send_char(DOT_CHAR); send_char(DOT_CHAR); send_char("b");
    end_name();                                   // empty label in the middle
    drain();

    // Label exactly at the limit, then one past it.
    send_label(MAX_LABEL, 1'b0);
    end_name();
    send_label(MAX_LABEL + 1, 1'b1);
    send_char(DOT_CHAR);
    send_char("z");
    end_name();
    drain();

    // Random names across four idling phases; drain at each phase change.
    base       = words_sent;
    last_phase = -1;
    while (words_sent - base < RANDOM_WORDS) begin
      phase = (words_sent - base) * 4 / RANDOM_WORDS;
      if (phase > 3) phase = 3;
      if (phase != last_phase) begin
        drain();
        case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 82; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 82; end
          default: begin idle_pct = 8; stall_pct = 8; end
        endcase
        last_phase = phase;
      end
      send_random_name();
    end

    // Close any name left open by a stray word, then let the pipe empty.
    end_name();
    drain();
    repeat (20) @(negedge clk);

    $display("Sent %0d words in %0d names; %0d wire bytes checked over four idling phases.",
             words_sent, names_sent, bytes_checked);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
